// File: sv/tsb_pkg.sv
// package for the two-stack text buffer: sizes, command and status codes,
// controller states and the memory port and result structs
// no dependencies
`timescale 1ns / 1ps

package tsb_pkg;

    // text capacity in bytes, split between the two stacks
    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // width that holds a count and an 8-bit position with room for a borrow
    localparam int WIDE_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam int CHAR_W = 8;
    localparam int FLD_W  = 8;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_DELETE    = 3'd1,
        CMD_BACKSPACE = 3'd2,
        CMD_MOVE      = 3'd3,
        CMD_REPLACE   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_TOPRD,
        S_EMIT
    } state_t;

    // one port set of a stack memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // result of one command, tops come from the memory read data
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] left_count;
        logic [CNT_W-1:0] right_count;
    } res_t;

endpackage

// File: sv/tsb_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module tsb_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int WORDS = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/tsb_ctrl.sv
// command sequencer: decodes a command, walks the stack memories for cursor
// moves and replace, then reads both tops; uses tsb_pkg
`timescale 1ns / 1ps

module tsb_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               command,
    input  logic [tsb_pkg::CHAR_W-1:0] char_value,
    input  logic [tsb_pkg::FLD_W-1:0]  position,
    input  logic [tsb_pkg::CHAR_W-1:0] replace_char,
    input  logic [tsb_pkg::CHAR_W-1:0] left_rdata,
    input  logic [tsb_pkg::CHAR_W-1:0] right_rdata,
    output tsb_pkg::mem_req_t        left_req,
    output tsb_pkg::mem_req_t        right_req,
    output logic                     res_valid,
    input  logic                     res_ready,
    output tsb_pkg::res_t            res
);

    import tsb_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   l_reg, l_next;
    logic [CNT_W-1:0]   r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic               pend_reg, pend_next;
    logic               shl_reg, shl_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [CHAR_W-1:0]  rep_reg, rep_next;
    status_t            status_reg, status_next;

    logic [WIDE_W-1:0]  pos_w, l_w, r_w;

    assign pos_w = WIDE_W'(position);
    assign l_w   = WIDE_W'(l_reg);
    assign r_w   = WIDE_W'(r_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            l_reg     <= '0;
            r_reg     <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            l_reg     <= l_next;
            r_reg     <= r_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers of the current command
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        rp_reg     <= rp_next;
        lim_reg    <= lim_next;
        wp_reg     <= wp_next;
        shl_reg    <= shl_next;
        ch_reg     <= ch_next;
        rep_reg    <= rep_next;
        status_reg <= status_next;
    end

    // next state, memory requests and handshakes
    always_comb begin
        state_next  = state_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        cnt_next    = cnt_reg;
        rp_next     = rp_reg;
        lim_next    = lim_reg;
        wp_next     = wp_reg;
        pend_next   = pend_reg;
        shl_next    = shl_reg;
        ch_next     = ch_reg;
        rep_next    = rep_reg;
        status_next = status_reg;
        left_req    = '0;
        right_req   = '0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    ch_next     = char_value;
                    rep_next    = replace_char;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    state_next  = S_TOPRD;
                    unique case (command)
                        CMD_INSERT: begin
                            if ((l_w + r_w) >= WIDE_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                left_req.we    = 1'b1;
                                left_req.waddr = l_reg[ADDR_W-1:0];
                                left_req.wdata = char_value;
                                l_next         = l_reg + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                r_next = r_reg - 1'b1;
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (l_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                l_next = l_reg - 1'b1;
                            end
                        end
                        CMD_MOVE: begin
                            if (pos_w < l_w) begin
                                // cursor goes left: left stack feeds right stack
                                cnt_next   = CNT_W'(l_w - pos_w);
                                shl_next   = 1'b1;
                                rp_next    = l_reg - 1'b1;
                                state_next = S_SHIFT;
                            end else if ((pos_w - l_w) > r_w) begin
                                status_next = ST_RANGE;
                            end else begin
                                cnt_next   = CNT_W'(pos_w - l_w);
                                shl_next   = 1'b0;
                                rp_next    = r_reg - 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_REPLACE: begin
                            rp_next    = '0;
                            lim_next   = (l_reg > r_reg) ? l_reg : r_reg;
                            state_next = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // finish the byte read last cycle
                if (pend_reg) begin
                    if (shl_reg) begin
                        right_req.we    = 1'b1;
                        right_req.waddr = r_reg[ADDR_W-1:0];
                        right_req.wdata = left_rdata;
                        l_next          = l_reg - 1'b1;
                        r_next          = r_reg + 1'b1;
                    end else begin
                        left_req.we    = 1'b1;
                        left_req.waddr = l_reg[ADDR_W-1:0];
                        left_req.wdata = right_rdata;
                        r_next         = r_reg - 1'b1;
                        l_next         = l_reg + 1'b1;
                    end
                end
                // fetch the next byte from the source stack
                if (cnt_reg != '0) begin
                    if (shl_reg) begin
                        left_req.re    = 1'b1;
                        left_req.raddr = rp_reg[ADDR_W-1:0];
                    end else begin
                        right_req.re    = 1'b1;
                        right_req.raddr = rp_reg[ADDR_W-1:0];
                    end
                    rp_next   = rp_reg - 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_TOPRD;
                end
            end

            S_SCAN: begin
                // write back matches of the entry read last cycle
                if (pend_reg) begin
                    if (left_rdata == ch_reg) begin
                        left_req.we    = 1'b1;
                        left_req.waddr = wp_reg;
                        left_req.wdata = rep_reg;
                    end
                    if (right_rdata == ch_reg) begin
                        right_req.we    = 1'b1;
                        right_req.waddr = wp_reg;
                        right_req.wdata = rep_reg;
                    end
                end
                // read the next entry of both stacks
                if (rp_reg < lim_reg) begin
                    left_req.re     = 1'b1;
                    left_req.raddr  = rp_reg[ADDR_W-1:0];
                    right_req.re    = 1'b1;
                    right_req.raddr = rp_reg[ADDR_W-1:0];
                    wp_next         = rp_reg[ADDR_W-1:0];
                    rp_next         = rp_reg + 1'b1;
                    pend_next       = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_TOPRD;
                end
            end

            S_TOPRD: begin
                left_req.re     = 1'b1;
                left_req.raddr  = ADDR_W'(l_reg - 1'b1);
                right_req.re    = 1'b1;
                right_req.raddr = ADDR_W'(r_reg - 1'b1);
                state_next      = S_EMIT;
            end

            S_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.left_count  = l_reg;
    assign res.right_count = r_reg;

endmodule

// File: sv/two_stack_text_buffer_unit.sv
// Two-stack (gap buffer) text store.
// Input stream s_*: one editing command per transfer (insert, delete right,
// backspace, move cursor, replace all). Output stream m_*: one result per
// command with status, both stack counts and both top bytes.
// Each command ends with a read of both tops (S_TOPRD) and the hand-off of
// its result to the output register (S_EMIT), which raises m_tvalid.
// Before that, insert, delete, backspace, bad codes and rejected moves
// need no steps; move by k places moves k bytes between stacks, one byte
// per cycle; replace all reads max(left_count, right_count) entries of
// each stack, one per cycle, and writes the matches back.
// The block takes one command at a time; s_tready rises again the cycle
// after the result is loaded into the output register, so a new command can
// be taken while that result still waits for m_tready.
// A stalled receiver holds m_tdata and m_tvalid; a finished command then
// waits until the output register is free.
// Reset (aresetn low, synchronous) empties both stacks; the memories need
// no clearing pass because no unwritten entry is ever used.
// uses tsb_pkg, tsb_ctrl and tsb_ram
`timescale 1ns / 1ps

module two_stack_text_buffer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], char_value[10:3], position[18:11], replace_char[26:19]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], left_count[9:2], right_count[17:10], left_top[25:18],
    // right_top[33:26]
    output logic [39:0] m_tdata
);

    import tsb_pkg::*;

    mem_req_t          left_req, right_req;
    logic [CHAR_W-1:0] left_rdata, right_rdata;
    logic              res_valid, res_ready;
    res_t              res;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg;
    logic [FLD_W-1:0]  lcount_reg, rcount_reg;
    logic [CHAR_W-1:0] ltop_reg, rtop_reg;

    // command sequencer
    tsb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_tvalid),
        .cmd_ready   (s_tready),
        .command     (s_tdata[2:0]),
        .char_value  (s_tdata[10:3]),
        .position    (s_tdata[18:11]),
        .replace_char(s_tdata[26:19]),
        .left_rdata  (left_rdata),
        .right_rdata (right_rdata),
        .left_req    (left_req),
        .right_req   (right_req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // left stack memory
    tsb_ram #(
        .DATA_W(CHAR_W),
        .ADDR_W(ADDR_W)
    ) u_left_ram (
        .aclk (aclk),
        .we   (left_req.we),
        .waddr(left_req.waddr),
        .wdata(left_req.wdata),
        .re   (left_req.re),
        .raddr(left_req.raddr),
        .rdata(left_rdata)
    );

    // right stack memory
    tsb_ram #(
        .DATA_W(CHAR_W),
        .ADDR_W(ADDR_W)
    ) u_right_ram (
        .aclk (aclk),
        .we   (right_req.we),
        .waddr(right_req.waddr),
        .wdata(right_req.wdata),
        .re   (right_req.re),
        .raddr(right_req.raddr),
        .rdata(right_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, empty sides read as zero
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            status_reg <= res.status;
            lcount_reg <= FLD_W'(res.left_count);
            rcount_reg <= FLD_W'(res.right_count);
            ltop_reg   <= (res.left_count != '0) ? left_rdata : '0;
            rtop_reg   <= (res.right_count != '0) ? right_rdata : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, rtop_reg, ltop_reg, rcount_reg, lcount_reg, status_reg};

`ifndef SYNTHESIS
    // one command at a time: ready drops after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while another is in progress");

    // text never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (({1'b0, m_tdata[9:2]} + {1'b0, m_tdata[17:10]}) <= 9'(DEPTH)))
        else $error("stack counts exceed capacity");

    // full status only when the text fills the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == ST_FULL)) |->
            (({1'b0, m_tdata[9:2]} + {1'b0, m_tdata[17:10]}) == 9'(DEPTH)))
        else $error("full status with room left");

    // an empty side reports a zero top byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[9:2] == 8'd0)) |-> (m_tdata[25:18] == 8'd0))
        else $error("left top nonzero on empty left stack");
`endif

endmodule
